[rtl/metronome_click_generator_top_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef METRONOME_CLICK_GENERATOR_TOP_MACROS_SVH
`define METRONOME_CLICK_GENERATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MCG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MCG_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MCG_ASSERT(label, clk, rst_n, prop, msg)
`define MCG_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

[rtl/mcg_pkg.sv]
package mcg_pkg;

  localparam int POS_BITS_DEF  = 41;
  localparam int CLICK_LEN_DEF = 1920;

  localparam int LOOP_W    = 40;
  localparam int BEAT_W    = 24;
  localparam int BAR_W     = 7;
  localparam int GAIN_W    = 16;
  localparam int FADE_W    = 18;
  localparam int LEVEL_W   = 15;
  localparam int AMP_W     = 13;
  localparam int SPAN_W    = 16;
  localparam int QL_W      = 13;
  localparam int MUL1_W    = AMP_W + SPAN_W;
  localparam int MUL2_W    = MUL1_W + GAIN_W;
  localparam int GAIN_SH   = 15;
  localparam int NUM_W     = MUL2_W - GAIN_SH;

  localparam logic [AMP_W-1:0]  AMP_ACCENT = 13'd5898;
  localparam logic [AMP_W-1:0]  AMP_PLAIN  = 13'd3604;
  localparam logic [GAIN_W-1:0] GAIN_ONE   = 16'h8000;

  localparam int IDX_W      = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [IDX_W-1:0] REG_CLICK_ENABLE = 3'd0;
  localparam logic [IDX_W-1:0] REG_BEAT_LENGTH  = 3'd1;
  localparam logic [IDX_W-1:0] REG_BAR_BEATS    = 3'd2;
  localparam logic [IDX_W-1:0] REG_LOOP_ON      = 3'd3;
  localparam logic [IDX_W-1:0] REG_LOOP_BEGIN   = 3'd4;
  localparam logic [IDX_W-1:0] REG_LOOP_FINISH  = 3'd5;

  typedef struct packed {
    logic              click_enable;
    logic [BEAT_W-1:0] beat_length;
    logic [BAR_W-1:0]  bar_beats;
    logic              loop_on;
    logic [LOOP_W-1:0] loop_begin;
    logic [LOOP_W-1:0] loop_finish;
  } cfg_t;

  typedef struct packed {
    logic              live;
    logic              mode;
    logic [GAIN_W-1:0] g;
  } ctx_t;

endpackage

[rtl/mcg_core.sv]
`include "metronome_click_generator_top_macros.svh"

module mcg_core #(
  parameter int POS_BITS  = mcg_pkg::POS_BITS_DEF,
  parameter int CLICK_LEN = mcg_pkg::CLICK_LEN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic                             in_take_i,
  input  mcg_pkg::cfg_t                    cfg_i,
  input  logic                             count_in_mode_i,
  input  logic [mcg_pkg::BEAT_W-1:0]       count_in_left_i,
  input  logic                             in_segment_i,
  input  logic signed [POS_BITS-1:0]       timeline_pos_i,
  input  logic signed [mcg_pkg::FADE_W-1:0] fade_gain_i,
  output logic                             out_valid_o,
  output logic [mcg_pkg::LEVEL_W-1:0]      click_level_o,
  output logic                             accent_beat_o
);

  localparam int P  = POS_BITS - 1;
  localparam int PW = ((P > mcg_pkg::LOOP_W) ? P : mcg_pkg::LOOP_W) + 1;
  localparam int LW = mcg_pkg::LOOP_W;
  localparam int BW = mcg_pkg::BEAT_W;
  localparam int RW = mcg_pkg::BAR_W;
  localparam int QW = mcg_pkg::QL_W;
  localparam int NW = mcg_pkg::NUM_W;

  // reciprocal of CLICK_LEN, exact for any NW-bit dividend
  localparam int RS  = NW + $clog2(CLICK_LEN);
  localparam int MW  = NW + 2;
  localparam int PRW = NW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << RS) + 64'(CLICK_LEN) - 64'd1) / 64'(CLICK_LEN));

  // loop length, refreshed every cycle from the static config
  logic [LW-1:0] len_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= cfg_i.loop_finish - cfg_i.loop_begin;
    end
  end

  logic [RW-1:0] per_bar;
  assign per_bar = (cfg_i.bar_beats == '0) ? RW'(1) : cfg_i.bar_beats;

  // entry decode
  logic [PW-1:0]              pos_ext, fin_ext, diff_c;
  logic                       wrap_c;
  mcg_pkg::ctx_t              ctx_c;
  logic [mcg_pkg::GAIN_W-1:0] g_c;

  always_comb begin
    pos_ext = PW'(timeline_pos_i[P-1:0]);
    fin_ext = PW'(cfg_i.loop_finish);
    diff_c  = pos_ext - fin_ext;
    wrap_c  = cfg_i.loop_on && (cfg_i.loop_finish > cfg_i.loop_begin) && (pos_ext >= fin_ext);
    if (fade_gain_i[mcg_pkg::FADE_W-1]) begin
      g_c = '0;
    end else if (fade_gain_i[mcg_pkg::FADE_W-2:0] > (mcg_pkg::FADE_W-1)'(mcg_pkg::GAIN_ONE)) begin
      g_c = mcg_pkg::GAIN_ONE;
    end else begin
      g_c = fade_gain_i[mcg_pkg::GAIN_W-1:0];
    end
    ctx_c.live = cfg_i.click_enable && (cfg_i.beat_length != '0) &&
                 (count_in_mode_i || (in_segment_i && !timeline_pos_i[POS_BITS-1]));
    ctx_c.mode = count_in_mode_i;
    ctx_c.g    = g_c;
  end

  // loop wrap: (pos - finish) mod len, one bit per stage
  logic                w_v    [0:P];
  mcg_pkg::ctx_t       w_ctx  [0:P];
  logic [P-1:0]        w_x    [0:P];
  logic [P-1:0]        w_pos  [0:P];
  logic [LW-1:0]       w_rem  [0:P];
  logic                w_wrap [0:P];
  logic [BW-1:0]       w_left [0:P];
  logic [LW-1:0]       w_rem_d[0:P-1];

  always_comb begin
    logic [LW:0] t;
    for (int k = 0; k < P; k++) begin
      t = {w_rem[k], w_x[k][P-1]};
      if (t >= {1'b0, len_q}) begin
        t = t - {1'b0, len_q};
      end
      w_rem_d[k] = t[LW-1:0];
    end
  end

  // beat division: dividend / beat_length, quotient folded mod bar length
  logic                d_v   [0:PW];
  mcg_pkg::ctx_t       d_ctx [0:PW];
  logic [PW-1:0]       d_n   [0:PW];
  logic [BW-1:0]       d_rem [0:PW];
  logic [RW-1:0]       d_bm  [0:PW];
  logic [BW-1:0]       d_rem_d[0:PW-1];
  logic [RW-1:0]       d_bm_d [0:PW-1];
  logic [PW-1:0]       div_in;

  always_comb begin
    logic [BW:0] t;
    logic [RW:0] u;
    logic        q;
    for (int k = 0; k < PW; k++) begin
      t = {d_rem[k], d_n[k][PW-1]};
      q = (t >= {1'b0, cfg_i.beat_length});
      if (q) begin
        t = t - {1'b0, cfg_i.beat_length};
      end
      d_rem_d[k] = t[BW-1:0];
      u = {d_bm[k], q};
      if (u >= {1'b0, per_bar}) begin
        u = u - {1'b0, per_bar};
      end
      d_bm_d[k] = u[RW-1:0];
    end
  end

  always_comb begin
    if (w_ctx[P].mode) begin
      div_in = PW'(w_left[P]);
    end else if (w_wrap[P]) begin
      div_in = PW'(cfg_i.loop_begin) + PW'(w_rem[P]);
    end else begin
      div_in = PW'(w_pos[P]);
    end
  end

  // phase, amplitude and envelope span
  logic [BW-1:0]              phase_c, rem_e;
  logic                       first_c, inclick_c;

  always_comb begin
    rem_e = d_rem[PW];
    if (d_ctx[PW].mode) begin
      phase_c = (rem_e == '0) ? '0 : (cfg_i.beat_length - rem_e);
    end else begin
      phase_c = rem_e;
    end
    first_c   = !d_ctx[PW].mode && (d_bm[PW] == '0);
    inclick_c = phase_c < BW'(CLICK_LEN);
  end

  logic                         f1_v, f1_on, f1_first;
  logic [mcg_pkg::AMP_W-1:0]    f1_amp;
  logic [mcg_pkg::SPAN_W-1:0]   f1_span;
  logic [mcg_pkg::GAIN_W-1:0]   f1_g, f2_g;
  logic                         f2_v, f2_on, f2_first;
  logic [mcg_pkg::MUL1_W-1:0]   f2_m1;
  logic                         f3_v, f3_on, f3_first;
  logic [mcg_pkg::MUL2_W-1:0]   f3_m2;

  // level = floor(m2 / 2^15 / CLICK_LEN) by reciprocal multiplication
  logic           l_v, l_on, l_first;
  logic [PRW-1:0] l_prod;
  logic [QW-1:0]  l_quo;

  assign l_quo = l_prod[RS +: QW];

  logic                        out_v_q, accent_q;
  logic [mcg_pkg::LEVEL_W-1:0] level_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= P; k++) w_v[k] <= 1'b0;
      for (int k = 0; k <= PW; k++) d_v[k] <= 1'b0;
      l_v     <= 1'b0;
      f1_v    <= 1'b0;
      f2_v    <= 1'b0;
      f3_v    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv_i) begin
      w_v[0] <= in_take_i;
      for (int k = 0; k < P; k++) w_v[k+1] <= w_v[k];
      d_v[0] <= w_v[P];
      for (int k = 0; k < PW; k++) d_v[k+1] <= d_v[k];
      f1_v    <= d_v[PW];
      f2_v    <= f1_v;
      f3_v    <= f2_v;
      l_v     <= f3_v;
      out_v_q <= l_v;
    end
  end

  // data path
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      w_ctx[0]  <= ctx_c;
      w_x[0]    <= diff_c[P-1:0];
      w_pos[0]  <= timeline_pos_i[P-1:0];
      w_rem[0]  <= '0;
      w_wrap[0] <= wrap_c;
      w_left[0] <= count_in_left_i;
      for (int k = 0; k < P; k++) begin
        w_ctx[k+1]  <= w_ctx[k];
        w_x[k+1]    <= w_x[k] << 1;
        w_pos[k+1]  <= w_pos[k];
        w_rem[k+1]  <= w_rem_d[k];
        w_wrap[k+1] <= w_wrap[k];
        w_left[k+1] <= w_left[k];
      end

      d_ctx[0] <= w_ctx[P];
      d_n[0]   <= div_in;
      d_rem[0] <= '0;
      d_bm[0]  <= '0;
      for (int k = 0; k < PW; k++) begin
        d_ctx[k+1] <= d_ctx[k];
        d_n[k+1]   <= d_n[k] << 1;
        d_rem[k+1] <= d_rem_d[k];
        d_bm[k+1]  <= d_bm_d[k];
      end

      f1_on    <= d_ctx[PW].live && inclick_c;
      f1_first <= first_c;
      f1_amp   <= first_c ? mcg_pkg::AMP_ACCENT : mcg_pkg::AMP_PLAIN;
      f1_span  <= mcg_pkg::SPAN_W'(CLICK_LEN) - phase_c[mcg_pkg::SPAN_W-1:0];
      f1_g     <= d_ctx[PW].mode ? mcg_pkg::GAIN_ONE : d_ctx[PW].g;

      f2_on    <= f1_on;
      f2_first <= f1_first;
      f2_g     <= f1_g;
      f2_m1    <= mcg_pkg::MUL1_W'(f1_amp) * mcg_pkg::MUL1_W'(f1_span);

      f3_on    <= f2_on;
      f3_first <= f2_first;
      f3_m2    <= mcg_pkg::MUL2_W'(f2_m1) * mcg_pkg::MUL2_W'(f2_g);

      l_on    <= f3_on;
      l_first <= f3_first;
      l_prod  <= PRW'(f3_m2[mcg_pkg::MUL2_W-1:mcg_pkg::GAIN_SH]) * PRW'(RECIP);

      level_q  <= l_on ? mcg_pkg::LEVEL_W'(l_quo) : '0;
      accent_q <= l_on && l_first && (l_quo != '0);
    end
  end

  assign out_valid_o   = out_v_q;
  assign click_level_o = level_q;
  assign accent_beat_o = accent_q;

  `MCG_ASSERT_NEVER(a_level_max, clk_i, rst_ni,
    out_v_q && (level_q > mcg_pkg::LEVEL_W'(mcg_pkg::AMP_ACCENT)), "click level above accent amplitude")
  `MCG_ASSERT_NEVER(a_accent_level, clk_i, rst_ni,
    out_v_q && accent_q && (level_q == '0), "accent flagged on a silent sample")
  `MCG_ASSERT(a_hold, clk_i, rst_ni,
    !adv_i |=> $stable(out_v_q) && $stable(level_q) && $stable(d_v[0]), "pipeline moved while held")
  `MCG_ASSERT_NEVER(a_wrap_rem, clk_i, rst_ni,
    w_v[P] && w_wrap[P] && (w_rem[P] >= len_q), "loop remainder not below loop length")

endmodule

[rtl/metronome_click_generator_top.sv]
// Metronome click generator. One result per sample, one sample accepted per clock cycle
// while the output is not stalled. The pipeline is a bit-serial loop-wrap remainder stage
// chain, a bit-serial divide by beat_length (which also folds the beat count into the bar),
// a phase stage, two multiplier stages, a reciprocal multiply for the click length and the
// output register. A stall on the output freezes the whole pipeline. Configuration writes
// are always accepted and must only be made while no transaction is in flight.
`include "metronome_click_generator_top_macros.svh"

module metronome_click_generator_top #(
  parameter int POS_BITS  = mcg_pkg::POS_BITS_DEF,
  parameter int CLICK_LEN = mcg_pkg::CLICK_LEN_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mcg_pkg::IDX_W-1:0]          cfg_index_i,
  input  logic [mcg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               count_in_mode_i,
  input  logic [mcg_pkg::BEAT_W-1:0]         count_in_left_i,
  input  logic                               in_segment_i,
  input  logic signed [POS_BITS-1:0]         timeline_pos_i,
  input  logic signed [mcg_pkg::FADE_W-1:0]  fade_gain_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mcg_pkg::LEVEL_W-1:0]        click_level_o,
  output logic                               accent_beat_o
);

  mcg_pkg::cfg_t cfg_q, cfg_d;
  logic          adv;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mcg_pkg::REG_CLICK_ENABLE: cfg_d.click_enable = cfg_data_i[0];
        mcg_pkg::REG_BEAT_LENGTH:  cfg_d.beat_length  = cfg_data_i[mcg_pkg::BEAT_W-1:0];
        mcg_pkg::REG_BAR_BEATS:    cfg_d.bar_beats    = cfg_data_i[mcg_pkg::BAR_W-1:0];
        mcg_pkg::REG_LOOP_ON:      cfg_d.loop_on      = cfg_data_i[0];
        mcg_pkg::REG_LOOP_BEGIN:   cfg_d.loop_begin   = cfg_data_i[mcg_pkg::LOOP_W-1:0];
        mcg_pkg::REG_LOOP_FINISH:  cfg_d.loop_finish  = cfg_data_i[mcg_pkg::LOOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.click_enable <= 1'b0;
      cfg_q.beat_length  <= mcg_pkg::BEAT_W'(24000);
      cfg_q.bar_beats    <= mcg_pkg::BAR_W'(4);
      cfg_q.loop_on      <= 1'b0;
      cfg_q.loop_begin   <= '0;
      cfg_q.loop_finish  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // whole pipeline moves unless the output register holds an untaken transaction
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  mcg_core #(
    .POS_BITS  (POS_BITS),
    .CLICK_LEN (CLICK_LEN)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .in_take_i       (in_valid_i),
    .cfg_i           (cfg_q),
    .count_in_mode_i (count_in_mode_i),
    .count_in_left_i (count_in_left_i),
    .in_segment_i    (in_segment_i),
    .timeline_pos_i  (timeline_pos_i),
    .fade_gain_i     (fade_gain_i),
    .out_valid_o     (out_valid_o),
    .click_level_o   (click_level_o),
    .accent_beat_o   (accent_beat_o)
  );

  `MCG_ASSERT(a_stall_map, clk_i, rst_ni,
    in_stall_o == (out_valid_o && out_stall_i), "input stall not tied to output hold")
  `MCG_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(click_level_o), "stalled result changed")
  `MCG_ASSERT(a_cfg_write, clk_i, rst_ni,
    cfg_valid_i && (cfg_index_i == mcg_pkg::REG_BEAT_LENGTH) |=>
      cfg_q.beat_length == $past(cfg_data_i[mcg_pkg::BEAT_W-1:0]), "beat length write lost")

endmodule
